[rtl/ipms_pkg.sv]
`default_nettype none

package ipms_pkg;

  // Fixed frame and number formats
  localparam int SlotCount = 4;
  localparam int FracBits  = 8;
  localparam int ErrW      = 17;
  localparam int AccW      = 24;
  localparam int CmdW      = 16;
  localparam int SumW      = 39;

  // Configuration register indexes
  localparam logic [2:0] CfgGainP     = 3'd0;
  localparam logic [2:0] CfgGainI     = 3'd1;
  localparam logic [2:0] CfgGainD     = 3'd2;
  localparam logic [2:0] CfgLimitHigh = 3'd3;
  localparam logic [2:0] CfgLimitLow  = 3'd4;

  // Reset values of the configuration registers
  localparam logic [15:0]        GainPReset     = 16'd6400;
  localparam logic [15:0]        GainIReset     = 16'd2560;
  localparam logic [15:0]        GainDReset     = 16'd0;
  localparam logic signed [15:0] LimitHighReset = 16'sd8000;
  localparam logic signed [15:0] LimitLowReset  = -16'sd8000;

  typedef logic signed [ErrW-1:0] err_t;
  typedef logic signed [AccW-1:0] acc_t;
  typedef logic signed [CmdW-1:0] cmd_t;
  typedef logic [1:0]             chan_idx_t;

  typedef struct packed {
    logic [15:0]        gain_p;
    logic [15:0]        gain_i;
    logic [15:0]        gain_d;
    logic signed [15:0] limit_high;
    logic signed [15:0] limit_low;
  } cfg_t;

  typedef struct packed {
    err_t e1;
    err_t e2;
    acc_t acc;
  } chan_state_t;

  typedef struct packed {
    logic        valid;
    chan_idx_t   idx;
    chan_state_t state;
    cmd_t        cmd;
  } chan_update_t;

endpackage

`default_nettype wire

[rtl/ipms_core.sv]
`default_nettype none

module ipms_core (
  input  ipms_pkg::cfg_t        cfg,
  input  logic signed [15:0]    measured_speed,
  input  logic signed [15:0]    target_speed,
  input  ipms_pkg::chan_state_t cur,
  output ipms_pkg::chan_state_t nxt,
  output ipms_pkg::cmd_t        cmd
);

  logic signed [16:0]                 e;
  logic signed [17:0]                 d1;
  logic signed [18:0]                 d2;
  logic signed [16:0]                 kp;
  logic signed [16:0]                 ki;
  logic signed [16:0]                 kd;
  logic signed [34:0]                 prod_p;
  logic signed [33:0]                 prod_i;
  logic signed [35:0]                 prod_d;
  logic signed [ipms_pkg::SumW-1:0]   acc_sum;
  logic signed [ipms_pkg::SumW-1:0]   hi;
  logic signed [ipms_pkg::SumW-1:0]   lo;
  ipms_pkg::acc_t                     acc_clamped;

  assign e  = {target_speed[15], target_speed} - {measured_speed[15], measured_speed};
  assign d1 = {e[16], e} - {cur.e1[16], cur.e1};
  // e - 2*e1 + e2
  assign d2 = {{2{e[16]}}, e} - {cur.e1[16], cur.e1, 1'b0} + {{2{cur.e2[16]}}, cur.e2};

  assign kp = $signed({1'b0, cfg.gain_p});
  assign ki = $signed({1'b0, cfg.gain_i});
  assign kd = $signed({1'b0, cfg.gain_d});

  assign prod_p = kp * d1;
  assign prod_i = ki * e;
  assign prod_d = kd * d2;

  assign acc_sum = ipms_pkg::SumW'(cur.acc) + ipms_pkg::SumW'(prod_p)
                 + ipms_pkg::SumW'(prod_i) + ipms_pkg::SumW'(prod_d);

  assign hi = ipms_pkg::SumW'($signed({cfg.limit_high, 8'h00}));
  assign lo = ipms_pkg::SumW'($signed({cfg.limit_low, 8'h00}));

  // Upper bound wins when the limits cross
  always_comb begin
    if (acc_sum > hi) begin
      acc_clamped = hi[ipms_pkg::AccW-1:0];
    end else if (acc_sum < lo) begin
      acc_clamped = lo[ipms_pkg::AccW-1:0];
    end else begin
      acc_clamped = acc_sum[ipms_pkg::AccW-1:0];
    end
  end

  assign nxt.e1  = e;
  assign nxt.e2  = cur.e1;
  assign nxt.acc = acc_clamped;
  assign cmd     = acc_clamped[ipms_pkg::AccW-1:ipms_pkg::FracBits];

endmodule

`default_nettype wire

[rtl/ipms_chan_state.sv]
`default_nettype none

module ipms_chan_state #(
  parameter int CHAN_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ipms_pkg::chan_idx_t    rd_idx,
  output ipms_pkg::chan_state_t  rd_state,
  input  ipms_pkg::chan_update_t upd,
  output ipms_pkg::cmd_t         slots [ipms_pkg::SlotCount]
);

  localparam int IdxW = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;

  ipms_pkg::chan_state_t state [CHAN_COUNT];
  ipms_pkg::cmd_t        frame [CHAN_COUNT];

  assign rd_state = state[rd_idx[IdxW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHAN_COUNT; i++) begin
        state[i] <= '0;
        frame[i] <= '0;
      end
    end else if (upd.valid) begin
      state[upd.idx[IdxW-1:0]] <= upd.state;
      frame[upd.idx[IdxW-1:0]] <= upd.cmd;
    end
  end

  // Slots with no channel behind them read as zero
  for (genvar j = 0; j < ipms_pkg::SlotCount; j++) begin : g_slot
    if (j < CHAN_COUNT) begin : g_live
      assign slots[j] = frame[j];
    end else begin : g_absent
      assign slots[j] = '0;
    end
  end

endmodule

`default_nettype wire

[rtl/incremental_pid_motor_speed.sv]
// An accepted item waits in the input register, then moves to the result register once
// that is free. Throughput: one item per cycle unless a stalled result blocks; the per-channel
// error and accumulator update (three gain multiplies, sum and clamp) is combinational.
// Reset (rst, synchronous, active high): clears all channel state, the command
// frame and both valid flags, and restores the default gains and limits.
`default_nettype none

module incremental_pid_motor_speed #(
  parameter int MOTOR_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         motor_index,
  input  logic signed [15:0] measured_speed,
  input  logic signed [15:0] target_speed,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         updated_motor,
  output logic signed [15:0] command_slot0,
  output logic signed [15:0] command_slot1,
  output logic signed [15:0] command_slot2,
  output logic signed [15:0] command_slot3,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // At most the four channels that the index can name ever hold state
  localparam int ChanCount = (MOTOR_COUNT < ipms_pkg::SlotCount) ?
                             MOTOR_COUNT : ipms_pkg::SlotCount;

  ipms_pkg::cfg_t        cfg;
  ipms_pkg::cfg_t        cfg_next;

  // Input register
  logic                  s0_valid;
  logic [1:0]            s0_motor;
  logic signed [15:0]    s0_meas;
  logic signed [15:0]    s0_targ;

  logic                  out_free;
  logic                  load;
  logic                  take;

  ipms_pkg::chan_state_t cur_state;
  ipms_pkg::chan_state_t nxt_state;
  ipms_pkg::cmd_t        nxt_cmd;
  ipms_pkg::chan_update_t upd;
  ipms_pkg::cmd_t        slots [ipms_pkg::SlotCount];

  // ---------------------------------------------------------------------------
  // Configuration: always ready; unknown indexes drop the write
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_next = cfg;
    case (cfg_index)
      ipms_pkg::CfgGainP:     cfg_next.gain_p     = cfg_data;
      ipms_pkg::CfgGainI:     cfg_next.gain_i     = cfg_data;
      ipms_pkg::CfgGainD:     cfg_next.gain_d     = cfg_data;
      ipms_pkg::CfgLimitHigh: cfg_next.limit_high = $signed(cfg_data);
      ipms_pkg::CfgLimitLow:  cfg_next.limit_low  = $signed(cfg_data);
      default:                cfg_next            = cfg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p     <= ipms_pkg::GainPReset;
      cfg.gain_i     <= ipms_pkg::GainIReset;
      cfg.gain_d     <= ipms_pkg::GainDReset;
      cfg.limit_high <= ipms_pkg::LimitHighReset;
      cfg.limit_low  <= ipms_pkg::LimitLowReset;
    end else if (cfg_valid && cfg_ready) begin
      cfg <= cfg_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. The result register frees up when it is empty or its item
  // is taken this cycle; the input register then hands its item over, and in
  // the same cycle can take a fresh one. Stall only when a held item has
  // nowhere to go.
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid || !out_stall;
  assign load     = s0_valid && out_free;
  assign in_stall = s0_valid && !out_free;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (take) begin
      s0_valid <= 1'b1;
    end else if (load) begin
      s0_valid <= 1'b0;
    end
  end

  // Payload needs no reset; hold it while stalled
  always_ff @(posedge clk) begin
    if (take) begin
      s0_motor <= motor_index;
      s0_meas  <= measured_speed;
      s0_targ  <= target_speed;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-channel state and the single-pass update. The state write and the
  // result load share one edge, so the next item in the input register
  // already sees the refreshed channel.
  // ---------------------------------------------------------------------------
  ipms_core u_core (
    .cfg            (cfg),
    .measured_speed (s0_meas),
    .target_speed   (s0_targ),
    .cur            (cur_state),
    .nxt            (nxt_state),
    .cmd            (nxt_cmd)
  );

  // Channels beyond the motor count leave every state untouched
  assign upd.valid = load && (int'(s0_motor) < ChanCount);
  assign upd.idx   = s0_motor;
  assign upd.state = nxt_state;
  assign upd.cmd   = nxt_cmd;

  ipms_chan_state #(
    .CHAN_COUNT (ChanCount)
  ) u_state (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (s0_motor),
    .rd_state (cur_state),
    .upd      (upd),
    .slots    (slots)
  );

  // ---------------------------------------------------------------------------
  // Result register. The command frame itself only changes on a load, so it
  // stays put while a result waits and serves directly as the slot payload.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      updated_motor <= s0_motor;
    end
  end

  assign command_slot0 = slots[0];
  assign command_slot1 = slots[1];
  assign command_slot2 = slots[2];
  assign command_slot3 = slots[3];

`ifndef SYNTH
  // A waiting result keeps its whole command frame
  a_frame_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(command_slot0) && $stable(command_slot1)
                               && $stable(command_slot2) && $stable(command_slot3))
    else $error("command frame changed while result stalled");

  // A held input item is not dropped while the result side is blocked
  a_input_kept: assert property (@(posedge clk) disable iff (rst)
    s0_valid && in_stall |=> s0_valid)
    else $error("input item lost while stalled");

  // A result only appears from an item held in the input register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s0_valid))
    else $error("result raised without an input item");
`endif

endmodule

`default_nettype wire

[verif/tb_incremental_pid_motor_speed.sv]
`timescale 1ns / 100ps

module tb_incremental_pid_motor_speed;

  localparam logic signed [15:0] SpeedMin = 16'sh8000;
  localparam logic signed [15:0] SpeedMax = 16'sh7FFF;
  localparam int RandomPhases   = 7;
  localparam int ItemsPerPhase  = 250;
  localparam int LongHoldCycles = 400;

  // One command frame as the block returns it.
  typedef struct packed {
    ipms_pkg::chan_idx_t                       motor;
    ipms_pkg::cmd_t [ipms_pkg::SlotCount-1:0] slot;
  } frame_t;

  // Speed loop model: own copy of the gains, limits and per-channel loop state.
  // note_sample works out the frame an accepted item must produce and queues it;
  // check_frame compares each returned frame with the oldest one queued.
  class speed_loop_board;
    logic [15:0]        kp, ki, kd;
    logic signed [15:0] lim_hi, lim_lo;
    ipms_pkg::err_t     last_err [ipms_pkg::SlotCount];
    ipms_pkg::err_t     older_err [ipms_pkg::SlotCount];
    ipms_pkg::acc_t     drive_acc [ipms_pkg::SlotCount];
    ipms_pkg::cmd_t     drive_cmd [ipms_pkg::SlotCount];
    frame_t             frames_due [$];
    int                 faults;

    function new();
      kp     = ipms_pkg::GainPReset;
      ki     = ipms_pkg::GainIReset;
      kd     = ipms_pkg::GainDReset;
      lim_hi = ipms_pkg::LimitHighReset;
      lim_lo = ipms_pkg::LimitLowReset;
      for (int i = 0; i < ipms_pkg::SlotCount; i++) begin
        last_err[i]  = '0;
        older_err[i] = '0;
        drive_acc[i] = '0;
        drive_cmd[i] = '0;
      end
      faults = 0;
    endfunction

    function void apply_setting(logic [2:0] idx, logic [15:0] data);
      case (idx)
        ipms_pkg::CfgGainP:     kp = data;
        ipms_pkg::CfgGainI:     ki = data;
        ipms_pkg::CfgGainD:     kd = data;
        ipms_pkg::CfgLimitHigh: lim_hi = data;
        ipms_pkg::CfgLimitLow:  lim_lo = data;
        default: ;
      endcase
    endfunction

    function void note_sample(ipms_pkg::chan_idx_t ch, logic signed [15:0] meas,
                              logic signed [15:0] targ);
      longint err, e1, e2, step, acc, hi, lo;
      frame_t due;
      err  = longint'(targ) - longint'(meas);
      e1   = longint'(last_err[ch]);
      e2   = longint'(older_err[ch]);
      hi   = longint'(lim_hi) * 256;
      lo   = longint'(lim_lo) * 256;
      step = longint'(kp) * (err - e1) + longint'(ki) * err
           + longint'(kd) * (err - 2 * e1 + e2);
      acc  = longint'(drive_acc[ch]) + step;
      // upper bound wins, also when the limits are crossed
      if (acc > hi)
        acc = hi;
      else if (acc < lo)
        acc = lo;
      drive_acc[ch] = ipms_pkg::acc_t'(acc);
      drive_cmd[ch] = ipms_pkg::cmd_t'(acc >>> 8);
      older_err[ch] = last_err[ch];
      last_err[ch]  = ipms_pkg::err_t'(err);
      due.motor = ch;
      for (int i = 0; i < ipms_pkg::SlotCount; i++)
        due.slot[i] = drive_cmd[i];
      frames_due.push_back(due);
    endfunction

    function void flag(string what, longint want, longint got);
      if (faults < 10)
        $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
      faults++;
    endfunction

    function void check_frame(frame_t seen);
      frame_t due;
      if (frames_due.size() == 0) begin
        flag("frame with nothing outstanding, motor", -1, seen.motor);
        return;
      end
      due = frames_due.pop_front();
      if (seen.motor !== due.motor)
        flag("updated_motor", due.motor, seen.motor);
      for (int i = 0; i < ipms_pkg::SlotCount; i++)
        if (seen.slot[i] !== due.slot[i])
          flag($sformatf("command_slot%0d", i), due.slot[i], seen.slot[i]);
    endfunction

    function int pending();
      return frames_due.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         motor_index = '0;
  logic signed [15:0] measured_speed = '0;
  logic signed [15:0] target_speed = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         updated_motor;
  logic signed [15:0] command_slot0, command_slot1, command_slot2, command_slot3;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  // set by the stimulus, cleared by the receiver once the long hold is over
  bit                 hold_off_due = 1'b0;
  speed_loop_board    board;

  incremental_pid_motor_speed uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .motor_index    (motor_index),
    .measured_speed (measured_speed),
    .target_speed   (target_speed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .updated_motor  (updated_motor),
    .command_slot0  (command_slot0),
    .command_slot1  (command_slot1),
    .command_slot2  (command_slot2),
    .command_slot3  (command_slot3),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch all three channels at the clock edge. Register writes and accepted
  // items go to the model before any frame is checked, so a frame can never
  // overtake the item that caused it.
  always @(posedge clk) begin
    frame_t seen;
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        board.apply_setting(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        board.note_sample(motor_index, measured_speed, target_speed);
      if (out_valid && !out_stall) begin
        seen.motor   = updated_motor;
        seen.slot[0] = command_slot0;
        seen.slot[1] = command_slot1;
        seen.slot[2] = command_slot2;
        seen.slot[3] = command_slot3;
        board.check_frame(seen);
      end
    end
  end

  // Receiver: switch between stall patterns of random length. When asked,
  // hold off completely for a long stretch so that the block fills up and
  // has to stall the sender.
  initial begin : result_stall
    int mode;
    int left;
    int held;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_due) begin
        out_stall <= 1'b1;
        for (held = 0; held < LongHoldCycles; held++)
          @(posedge clk);
        hold_off_due = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 300);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 75);
          default: out_stall <= (left % 3 != 0);
        endcase
      end
    end
  end

  // Offer one item and hold it until the block takes it. Valid stays high on
  // return so that a following item goes out back to back.
  task automatic offer_sample(ipms_pkg::chan_idx_t m, logic signed [15:0] meas,
                              logic signed [15:0] targ);
    in_valid       <= 1'b1;
    motor_index    <= m;
    measured_speed <= meas;
    target_speed   <= targ;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait until every frame owed has come back, then let the
  // pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
  endtask

  task automatic close_registers();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return 16'h0000;
    if (r == 1)
      return 16'hFFFF;
    if (r <= 3)
      return 16'($urandom);
    return 16'($urandom_range(0, 1500));
  endfunction

  // Fresh gains and limits for one random phase: mostly ordered limits,
  // sometimes the extremes, sometimes crossed.
  task automatic pick_settings();
    logic signed [15:0] a, b;
    int r;
    set_register(ipms_pkg::CfgGainP, pick_gain());
    set_register(ipms_pkg::CfgGainI, pick_gain());
    set_register(ipms_pkg::CfgGainD, pick_gain());
    r = $urandom_range(0, 7);
    if (r == 0) begin
      a = SpeedMax;
      b = SpeedMin;
    end else if (r == 1) begin
      a = -$signed(16'($urandom_range(0, 5000)));
      b = 16'($urandom_range(0, 5000));
    end else if (r == 2) begin
      a = 16'($urandom);
      b = 16'($urandom);
    end else begin
      a = 16'($urandom_range(100, 20000));
      b = -a;
    end
    set_register(ipms_pkg::CfgLimitHigh, a);
    set_register(ipms_pkg::CfgLimitLow, b);
    // indexes past the register list must leave everything alone
    if ($urandom_range(0, 2) == 0)
      set_register(3'($urandom_range(5, 7)), 16'($urandom));
    close_registers();
  endtask

  // Mostly samples close to the set point, so the loop works away from the
  // limits; the rest full-range noise and the corner values.
  task automatic random_sample();
    logic signed [15:0] targ, meas;
    logic signed [15:0] corner [4];
    int r;
    corner[0] = SpeedMin;
    corner[1] = SpeedMax;
    corner[2] = 16'sd0;
    corner[3] = -16'sd1;
    r = $urandom_range(0, 9);
    if (r <= 6) begin
      targ = 16'($urandom);
      meas = targ - 16'($urandom_range(0, 600)) + 16'sd300;
    end else if (r <= 8) begin
      targ = 16'($urandom);
      meas = 16'($urandom);
    end else begin
      targ = corner[$urandom_range(0, 3)];
      meas = corner[$urandom_range(0, 3)];
    end
    offer_sample(2'($urandom_range(0, 3)), meas, targ);
  endtask

  initial begin : stimulus
    int phase;
    int sent;
    int burst;
    bit eager;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Default gains: full-scale errors both ways drive the channels into both
    // limits, then back out again.
    offer_sample(2'd0, SpeedMin, SpeedMax);
    offer_sample(2'd1, SpeedMax, SpeedMin);
    offer_sample(2'd2, 16'sd0, 16'sd0);
    offer_sample(2'd3, -16'sd1, 16'sd1);
    offer_sample(2'd0, SpeedMax, SpeedMin);
    offer_sample(2'd1, 16'sd0, 16'sd0);
    offer_sample(2'd2, 16'sd1234, 16'sd1300);
    offer_sample(2'd3, SpeedMin, SpeedMin);
    drain();

    // Largest gains and the widest limits; stray writes past the list.
    set_register(ipms_pkg::CfgGainP, 16'hFFFF);
    set_register(ipms_pkg::CfgGainI, 16'hFFFF);
    set_register(ipms_pkg::CfgGainD, 16'hFFFF);
    set_register(ipms_pkg::CfgLimitHigh, SpeedMax);
    set_register(ipms_pkg::CfgLimitLow, SpeedMin);
    set_register(3'd5, 16'h1234);
    set_register(3'd6, 16'hFFFF);
    set_register(3'd7, 16'h0000);
    close_registers();
    offer_sample(2'd0, SpeedMin, SpeedMax);
    offer_sample(2'd1, SpeedMax, SpeedMin);
    offer_sample(2'd0, SpeedMax, SpeedMin);
    offer_sample(2'd1, SpeedMin, SpeedMax);
    offer_sample(2'd2, 16'sd0, 16'sd0);
    offer_sample(2'd3, 16'sd100, 16'sd99);
    offer_sample(2'd0, 16'sd0, 16'sd0);
    offer_sample(2'd1, 16'sd0, 16'sd0);
    drain();

    // Crossed limits: the upper test still comes first.
    set_register(ipms_pkg::CfgGainP, 16'd0);
    set_register(ipms_pkg::CfgGainI, 16'd256);
    set_register(ipms_pkg::CfgGainD, 16'd0);
    set_register(ipms_pkg::CfgLimitHigh, -16'sd100);
    set_register(ipms_pkg::CfgLimitLow, 16'sd100);
    close_registers();
    offer_sample(2'd0, 16'sd10, 16'sd20);
    offer_sample(2'd1, 16'sd20, 16'sd10);
    offer_sample(2'd2, 16'sd0, 16'sd0);
    offer_sample(2'd3, SpeedMax, SpeedMin);
    drain();

    // Zero gains and limits pinned at zero.
    set_register(ipms_pkg::CfgGainP, 16'd0);
    set_register(ipms_pkg::CfgGainI, 16'd0);
    set_register(ipms_pkg::CfgGainD, 16'd0);
    set_register(ipms_pkg::CfgLimitHigh, 16'sd0);
    set_register(ipms_pkg::CfgLimitLow, 16'sd0);
    close_registers();
    offer_sample(2'd0, SpeedMin, SpeedMax);
    offer_sample(2'd1, SpeedMax, SpeedMin);
    offer_sample(2'd2, 16'sd5, 16'sd7);
    offer_sample(2'd3, 16'sd0, 16'sd0);
    drain();

    // Random phases, each under its own settings. Two of them start with a
    // long hold-off on the result side; one runs with no sender gaps at all.
    for (phase = 0; phase < RandomPhases; phase++) begin
      pick_settings();
      if (phase == 1 || phase == 4)
        hold_off_due = 1'b1;
      eager = (phase == 2);
      sent = 0;
      while (sent < ItemsPerPhase) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < ItemsPerPhase; k++) begin
          random_sample();
          sent++;
        end
        if (!eager && $urandom_range(0, 9) >= 3)
          pause_sender($urandom_range(1, 8));
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (board.faults == 0 && board.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
